>>> hw/rtl/pcma_pkg.sv
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types and constants for the PWM capture moving-average block.
// ----------------------------------------------------------------------------
package pcma_pkg;

    // Window length and the running-sum width it implies
    localparam int WINDOW  = 5;
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int TIME_W  = 32;
    localparam int TOTAL_W = TIME_W + LOG_W;

    // Reciprocal divide: q = (total * RECIP) >> DIV_SHIFT, exact for any
    // TOTAL_W-bit total (round-up reciprocal).
    localparam int DIV_SHIFT = TOTAL_W + LOG_W;
    localparam int M_W       = TOTAL_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

    // Partial-product split point
    localparam int SPLIT  = 20;
    localparam int T_HI_W = TOTAL_W - SPLIT;
    localparam int M_HI_W = M_W - SPLIT;
    localparam int P_W    = TOTAL_W + M_W;

    typedef struct packed {
        logic              rise_edge;
        logic              fall_edge;
        logic [TIME_W-1:0] time_ms;
    } t_in_beat;

    typedef struct packed {
        logic [TIME_W-1:0] mean_period;
        logic [TIME_W-1:0] mean_on_time;
    } t_out_beat;

    // Stage load strobes for the divider pipeline
    typedef struct packed {
        logic ld_prod;
        logic ld_out;
    } t_div_ctl;

endpackage

>>> hw/rtl/pcma_window.sv
// ----------------------------------------------------------------------------
// pcma_window
// Sliding window of samples with a running sum; oldest drops out on a push.
// ----------------------------------------------------------------------------
module pcma_window
    import pcma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [TIME_W-1:0]  i_sample,
    output logic [TOTAL_W-1:0] o_total
);

    logic [TIME_W-1:0]  r_win [WINDOW];
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;

    assign n_total = r_total - TOTAL_W'(r_win[0]) + TOTAL_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
            end
            r_total <= '0;
        end else if (i_push) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WINDOW-1] <= i_sample;
            r_total         <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

>>> hw/rtl/pcma_div.sv
// ----------------------------------------------------------------------------
// pcma_div
// Divide a window sum by WINDOW: registered partial products, then sum/select.
// ----------------------------------------------------------------------------
module pcma_div
    import pcma_pkg::*;
(
    input  logic               i_clk,
    input  t_div_ctl           i_ctl,
    input  logic [TOTAL_W-1:0] i_total,
    output logic [TIME_W-1:0]  o_quot
);

    localparam logic [SPLIT-1:0]  M_LO = RECIP[SPLIT-1:0];
    localparam logic [M_HI_W-1:0] M_HI = RECIP[M_W-1:SPLIT];

    logic [SPLIT-1:0]         t_lo;
    logic [T_HI_W-1:0]        t_hi;
    logic [2*SPLIT-1:0]       r_pp_ll;
    logic [SPLIT+M_HI_W-1:0]  r_pp_lh;
    logic [T_HI_W+SPLIT-1:0]  r_pp_hl;
    logic [T_HI_W+M_HI_W-1:0] r_pp_hh;
    logic [P_W-1:0]           prod;
    logic [TIME_W-1:0]        r_quot;

    assign t_lo = i_total[SPLIT-1:0];
    assign t_hi = i_total[TOTAL_W-1:SPLIT];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_pp_ll <= (2*SPLIT)'(t_lo) * (2*SPLIT)'(M_LO);
            r_pp_lh <= (SPLIT+M_HI_W)'(t_lo) * (SPLIT+M_HI_W)'(M_HI);
            r_pp_hl <= (T_HI_W+SPLIT)'(t_hi) * (T_HI_W+SPLIT)'(M_LO);
            r_pp_hh <= (T_HI_W+M_HI_W)'(t_hi) * (T_HI_W+M_HI_W)'(M_HI);
        end
    end

    assign prod = P_W'(r_pp_ll)
                + (P_W'(r_pp_lh) << SPLIT)
                + (P_W'(r_pp_hl) << SPLIT)
                + (P_W'(r_pp_hh) << (2*SPLIT));

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_quot <= prod[DIV_SHIFT +: TIME_W];
        end
    end

    assign o_quot = r_quot;

endmodule

>>> hw/rtl/pwm_capture_moving_average.sv
// ----------------------------------------------------------------------------
// pwm_capture_moving_average
// PWM edge capture with moving averages of period and on-time.
// ----------------------------------------------------------------------------
//
//  channel | valid        | ready        | beat       | carries
//  --------+--------------+--------------+------------+---------------------------
//  in      | i_in_valid   | o_in_ready   | i_in_beat  | rise/fall flags, time_ms
//  out     | o_out_valid  | i_out_ready  | o_out_beat | mean_period, mean_on_time
//
//  One beat in per cycle, sustained while the output is not stalled; one result beat per input beat.
//  Stages in order: window update, partial products of the reciprocal
//  multiply, then sum and select into the output register.
//  Synchronous active-low reset clears the windows, sums, last rise time and
//  all stage valids.
//  Stages advance independently; an output stall fills bubbles first, and
//  input ready drops only once the window stage is held.
//
module pwm_capture_moving_average
    import pcma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    // Edge state
    logic [TIME_W-1:0] r_last_rise;
    logic              r_rise_seen;

    // Stage valids: s1 = window sums, s2 = partial products, s3 = output
    logic r_v1;
    logic r_v2;
    logic r_v3;

    logic accept;
    logic adv1;
    logic adv2;
    logic out_free;

    logic              push_period;
    logic              push_on;
    logic [TIME_W-1:0] period_sample;
    logic [TIME_W-1:0] on_sample;

    logic [TOTAL_W-1:0] period_total;
    logic [TOTAL_W-1:0] on_time_total;
    t_div_ctl           div_ctl;

    // Handshake and stage advance
    assign out_free   = !r_v3 || i_out_ready;
    assign adv2       = r_v2 && out_free;
    assign adv1       = r_v1 && (!r_v2 || adv2);
    // s1 payload is the live sums, so they may only change once s1 moves on
    assign o_in_ready = !r_v1 || adv1;
    assign accept     = i_in_valid && o_in_ready;

    // A rise after an earlier rise pushes the period; a fall after any rise
    // (this beat's included) pushes the on-time, zero when both flags are set.
    assign push_period   = accept && i_in_beat.rise_edge && r_rise_seen;
    assign push_on       = accept && i_in_beat.fall_edge
                        && (r_rise_seen || i_in_beat.rise_edge);
    assign period_sample = i_in_beat.time_ms - r_last_rise;
    assign on_sample     = i_in_beat.rise_edge ? '0 : (i_in_beat.time_ms - r_last_rise);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rise <= '0;
            r_rise_seen <= 1'b0;
        end else if (accept && i_in_beat.rise_edge) begin
            r_last_rise <= i_in_beat.time_ms;
            r_rise_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (i_out_ready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    pcma_window u_period_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push_period),
        .i_sample (period_sample),
        .o_total  (period_total)
    );

    pcma_window u_on_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push_on),
        .i_sample (on_sample),
        .o_total  (on_time_total)
    );

    assign div_ctl.ld_prod = adv1;
    assign div_ctl.ld_out  = adv2;

    pcma_div u_period_div (
        .i_clk   (i_clk),
        .i_ctl   (div_ctl),
        .i_total (period_total),
        .o_quot  (o_out_beat.mean_period)
    );

    pcma_div u_on_div (
        .i_clk   (i_clk),
        .i_ctl   (div_ctl),
        .i_total (on_time_total),
        .o_quot  (o_out_beat.mean_on_time)
    );

    assign o_out_valid = r_v3;

    // Checks
    a_rise_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rise_seen |=> r_rise_seen)
        else $error("rise_seen cleared outside reset");

    a_last_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_beat.rise_edge) |=> (r_last_rise == $past(i_in_beat.time_ms)))
        else $error("last rise time not captured");

    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> r_v2)
        else $error("beat lost between window and product stages");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result beat changed");

endmodule

>>> bench/tb_pwm_capture_moving_average.sv
// ----------------------------------------------------------------------------
// tb_pwm_capture_moving_average
// Self-checking bench for the PWM capture moving-average block: edge beats
// go in, and every result beat is checked against a model of the period and
// on-time windows. Directed corner cases come first, then pulse trains with
// noise mixed in under several flow-control mixes and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_pwm_capture_moving_average;
    import pcma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime     CLK_HALF     = 1.0;
    localparam int          RESET_CYCLES = 4;
    localparam int          HOLD_CYCLES  = 200;  // long output hold-off
    localparam int          DRAIN_SLACK  = 10;
    localparam int          REPORT_MAX   = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // Model of the two windows plus the queue of expected result beats.
    // note_edge() takes each accepted edge beat, check_means() each result.
    // ------------------------------------------------------------------------
    class pwm_mean_board;
        logic [TIME_W-1:0] last_rise;
        bit                seen_rise;
        logic [TIME_W-1:0] period_win[$];
        logic [TIME_W-1:0] on_win[$];
        t_out_beat         pending_means[$];
        int unsigned       n_edges, n_means, n_rise, n_fall_used, n_fall_dropped;
        int unsigned       n_both, n_bad;

        function new();
            last_rise = '0;
            seen_rise = 1'b0;
            repeat (WINDOW) begin
                period_win.push_back('0);
                on_win.push_back('0);
            end
            n_edges = 0;
            n_means = 0;
            n_rise = 0;
            n_fall_used = 0;
            n_fall_dropped = 0;
            n_both = 0;
            n_bad = 0;
        endfunction

        // Unfilled slots hold zero, so the sum is always over WINDOW entries
        static function logic [TIME_W-1:0] window_mean(input logic [TIME_W-1:0] win[$]);
            logic [TOTAL_W-1:0] total;
            total = '0;
            foreach (win[k])
                total += TOTAL_W'(win[k]);
            return TIME_W'(total / TOTAL_W'(WINDOW));
        endfunction

        function void note_edge(input t_in_beat b);
            t_out_beat m;
            n_edges++;
            if (b.rise_edge && b.fall_edge)
                n_both++;
            // rise is handled first; a fall in the same beat then measures zero
            if (b.rise_edge) begin
                if (seen_rise) begin
                    void'(period_win.pop_front());
                    period_win.push_back(TIME_W'(b.time_ms - last_rise));
                end
                last_rise = b.time_ms;
                seen_rise = 1'b1;
                n_rise++;
            end
            if (b.fall_edge) begin
                if (seen_rise) begin
                    void'(on_win.pop_front());
                    on_win.push_back(TIME_W'(b.time_ms - last_rise));
                    n_fall_used++;
                end else begin
                    n_fall_dropped++;
                end
            end
            m.mean_period  = window_mean(period_win);
            m.mean_on_time = window_mean(on_win);
            pending_means.push_back(m);
        endfunction

        function void check_means(input t_out_beat got);
            t_out_beat want;
            if (pending_means.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_MAX)
                    $display("%0t: result beat with nothing pending: period %0d on-time %0d",
                             $realtime, got.mean_period, got.mean_on_time);
                return;
            end
            want = pending_means.pop_front();
            if (got.mean_period !== want.mean_period
                    || got.mean_on_time !== want.mean_on_time) begin
                n_bad++;
                if (n_bad <= REPORT_MAX)
                    $display("%0t: result %0d: period exp %0d got %0d, on-time exp %0d got %0d",
                             $realtime, n_means, want.mean_period, got.mean_period,
                             want.mean_on_time, got.mean_on_time);
            end
            n_means++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block itself
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_beat;

    pwm_capture_moving_average uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    pwm_mean_board board = new();

    // Flow-control knobs. stall_pct and hold_off are read by the receiver at
    // the clock edge, so they only ever change by nonblocking assignment.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_off      = 1'b0;
    int unsigned cycle_count   = 0;

    // Pulse-train generator state
    logic [TIME_W-1:0] train_t      = '0;
    logic [TIME_W-1:0] train_period = 32'd100;
    logic [TIME_W-1:0] train_on     = 32'd40;
    bit                train_high   = 1'b0;

    // ------------------------------------------------------------------------
    // Monitors: both sample at the edge, before any nonblocking update lands
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_edge(i_in_beat);
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_means(o_out_beat);
    end

    // Receiver: random stalls, or a solid hold-off while hold_off is set
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, board.pending_means.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    function automatic t_in_beat edge_beat(input bit rise, input bit fall,
                                           input logic [TIME_W-1:0] t);
        t_in_beat b;
        b.rise_edge = rise;
        b.fall_edge = fall;
        b.time_ms   = t;
        return b;
    endfunction

    // Called right after the clock rises. Valid is only lowered when a gap is
    // taken, so back-to-back beats never see valid lowered and raised between them.
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_beat  <= t_in_beat'({2'($urandom_range(3)), $urandom()});  // junk while idle
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // Mostly well-formed rise/fall trains with random content; the rest is
    // noise with random flags and timestamps anywhere in the 32-bit range.
    task automatic pick_edge(output t_in_beat b);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            b = edge_beat(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
        end else begin
            if (roll < 17) begin
                // fresh train, anywhere in time; now and then a huge period
                train_t      = $urandom();
                train_period = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 5000);
                train_on     = $urandom_range(0, train_period);
                train_high   = 1'b0;
            end
            if (!train_high) begin
                // occasionally a pulse too narrow to split: both flags at once
                b = edge_beat(1'b1, (roll < 20), train_t);
                train_high = (roll >= 20);
                if (roll < 20)
                    train_t = train_t + train_period;
            end else begin
                b = edge_beat(1'b0, 1'b1, train_t + train_on + $urandom_range(0, 2));
                train_t    = train_t + train_period + $urandom_range(0, 3);
                train_high = 1'b0;
            end
        end
    endtask

    task automatic send_random(input int count);
        t_in_beat b;
        repeat (count) begin
            pick_edge(b);
            send_beat(b);
        end
    endtask

    task automatic set_mix(input int unsigned send_pct, input int unsigned stall);
        send_idle_pct = send_pct;
        stall_pct    <= stall;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, no idling
        set_mix(0, 0);
        send_beat(edge_beat(1'b0, 1'b1, 32'd100));        // fall before any rise: ignored
        send_beat(edge_beat(1'b0, 1'b0, 32'd7));          // no flags
        send_beat(edge_beat(1'b1, 1'b0, 32'd0));          // first rise, no period yet
        send_beat(edge_beat(1'b0, 1'b1, 32'hFFFF_FFFF));  // widest on-time
        send_beat(edge_beat(1'b1, 1'b0, 32'hFFFF_FFFF));  // widest period
        send_beat(edge_beat(1'b1, 1'b0, 32'hFFFF_FFFE));  // time runs backwards, wraps
        send_beat(edge_beat(1'b1, 1'b0, 32'hFFFF_FFFD));
        send_beat(edge_beat(1'b1, 1'b1, 32'hFFFF_FFFC));  // both flags: on-time of zero
        send_beat(edge_beat(1'b1, 1'b0, 32'hFFFF_FFFB));  // period window now all max
        repeat (5)
            send_beat(edge_beat(1'b0, 1'b1, 32'hFFFF_FFFA));  // on-time window all max
        send_beat(edge_beat(1'b0, 1'b0, 32'h5A5A_A5A5));
        send_beat(edge_beat(1'b1, 1'b1, 32'd0));          // wraps forward by five
        send_beat(edge_beat(1'b0, 1'b1, 32'h8000_0000));
        send_beat(edge_beat(1'b1, 1'b0, 32'h0000_0001));
        send_beat(edge_beat(1'b0, 1'b0, 32'hFFFF_FFFF));

        // Random trains under each flow-control mix
        set_mix(0, 0);
        send_random(140);
        set_mix(73, 0);
        send_random(130);
        set_mix(0, 73);
        send_random(130);
        set_mix(23, 23);
        send_random(110);

        // Output held off while the sender keeps pushing: the pipe fills and
        // input ready has to drop until the hold is lifted
        set_mix(0, 0);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            send_random(40);
        join
        i_in_valid <= 1'b0;

        while (board.pending_means.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);

        $display("%0d edge beats in (%0d rises, %0d falls measured, %0d falls before a rise,",
                 board.n_edges, board.n_rise, board.n_fall_used, board.n_fall_dropped);
        $display("%0d with both flags), %0d mean beats checked, %0d mismatches",
                 board.n_both, board.n_means, board.n_bad);
        if (board.n_bad == 0 && board.pending_means.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pcma_pkg.sv
hw/rtl/pcma_window.sv
hw/rtl/pcma_div.sv
hw/rtl/pwm_capture_moving_average.sv
bench/tb_pwm_capture_moving_average.sv
